@@ sv/alist_pkg.sv @@
`default_nettype none

package alist_pkg;

  // list capacity and the widths that follow from it
  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int DATA_W     = 32;
  localparam int POS_W      = 6;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_RM,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

@@ sv/alist_ram.sv @@
`default_nettype none

// simple dual-port RAM: one write port, one read port, registered read
module alist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ sv/array_list_engine_top.sv @@
`default_nettype none

// Channel  Dir  Handshake            Beat
// in_      in   in_valid/in_ready    func, item_value, position
// out_     out  out_valid/out_ready  status, found, removed_value, entry_count, is_empty
//
// Insert and clear go straight to the output state, and the result is shown from the output register.
// Search: one RAM read per entry, each compared once its registered read data returns, early exit on a hit.
// Remove: one read/write pass from the position to the end; a missing position goes straight to output.
// The RAM port (one read, one write per cycle) sets the pace of search and remove.
// in_ready is low while an item is worked on and while its result waits.
// Reset clears the state, the count and the pending flag only; the entry RAM needs no clearing pass.

module array_list_engine_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [1:0]                            in_func,
  input  wire logic signed [alist_pkg::DATA_W-1:0]   in_item_value,
  input  wire logic [alist_pkg::POS_W-1:0]           in_position,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [1:0]                                 out_status,
  output logic                                       out_found,
  output logic signed [alist_pkg::DATA_W-1:0]        out_removed_value,
  output logic [alist_pkg::COUNT_OUT_W-1:0]          out_entry_count,
  output logic                                       out_is_empty
);

  localparam int IDX_W  = alist_pkg::IDX_W;
  localparam int CNT_W  = alist_pkg::CNT_W;
  localparam int DATA_W = alist_pkg::DATA_W;
  localparam int POS_W  = alist_pkg::POS_W;
  localparam int OUT_W  = alist_pkg::COUNT_OUT_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(alist_pkg::LIST_DEPTH);

  alist_pkg::state_t  state_r, state_nxt;
  alist_pkg::status_t status_r, status_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic               pend_r, pend_nxt;
  logic               first_r, first_nxt;
  logic               found_r, found_nxt;
  logic [DATA_W-1:0]  key_r, key_nxt;
  logic [DATA_W-1:0]  removed_r, removed_nxt;

  // RAM ports
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [DATA_W-1:0]  wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [DATA_W-1:0]  rd_data;

  // common-width views for compares against the count
  logic [CNT_W+POS_W-1:0] pos_ext;
  logic [CNT_W+POS_W-1:0] cnt_ext;
  logic [CNT_W+OUT_W-1:0] cnt_out_ext;
  logic                   issue;

  assign pos_ext     = {{CNT_W{1'b0}}, in_position};
  assign cnt_ext     = {{POS_W{1'b0}}, count_r};
  assign cnt_out_ext = {{OUT_W{1'b0}}, count_r};
  assign issue       = (idx_r < count_r);

  alist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (alist_pkg::LIST_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alist_pkg::S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    idx_r       <= idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    first_r     <= first_nxt;
    found_r     <= found_nxt;
    key_r       <= key_nxt;
    removed_r   <= removed_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    key_nxt       = key_r;
    removed_nxt   = removed_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data       = key_r;
    rd_addr       = idx_r[IDX_W-1:0];

    unique case (state_r)
      alist_pkg::S_IDLE: begin
        if (in_valid) begin
          status_nxt  = alist_pkg::STAT_OK;
          found_nxt   = 1'b0;
          removed_nxt = '0;
          key_nxt     = in_item_value;
          pend_nxt    = 1'b0;
          first_nxt   = 1'b1;
          unique case (alist_pkg::op_t'(in_func))
            alist_pkg::OP_INSERT: begin
              if (count_r == DEPTH_C) begin
                status_nxt = alist_pkg::STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_data   = in_item_value;
                count_nxt = count_r + CNT_W'(1);
              end
              state_nxt = alist_pkg::S_OUT;
            end
            alist_pkg::OP_SEARCH: begin
              idx_nxt   = '0;
              state_nxt = alist_pkg::S_SRCH;
            end
            alist_pkg::OP_REMOVE: begin
              if (pos_ext >= cnt_ext) begin
                status_nxt = alist_pkg::STAT_MISSING;
                state_nxt  = alist_pkg::S_OUT;
              end else begin
                idx_nxt   = pos_ext[CNT_W-1:0];
                state_nxt = alist_pkg::S_RM;
              end
            end
            alist_pkg::OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = alist_pkg::S_OUT;
            end
          endcase
        end
      end

      // read one entry a cycle, compare the one read last cycle
      alist_pkg::S_SRCH: begin
        pend_nxt = issue;
        idx_nxt  = issue ? idx_r + CNT_W'(1) : idx_r;
        if (pend_r && rd_data == key_r) begin
          found_nxt = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = alist_pkg::S_OUT;
        end else if (!pend_r && !issue) begin
          state_nxt = alist_pkg::S_OUT;
        end
      end

      // first read returns the removed entry, later ones move down by one
      alist_pkg::S_RM: begin
        pend_nxt      = issue;
        pend_addr_nxt = idx_r[IDX_W-1:0];
        idx_nxt       = issue ? idx_r + CNT_W'(1) : idx_r;
        if (pend_r) begin
          first_nxt = 1'b0;
          if (first_r) begin
            removed_nxt = rd_data;
          end else begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_r - IDX_W'(1);
            wr_data = rd_data;
          end
        end
        if (!pend_r && !issue) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = alist_pkg::S_OUT;
        end
      end

      alist_pkg::S_OUT: begin
        if (out_ready) begin
          state_nxt = alist_pkg::S_IDLE;
        end
      end

      default: state_nxt = alist_pkg::S_IDLE;
    endcase
  end

  // outputs; count is stable while the result waits
  assign in_ready          = (state_r == alist_pkg::S_IDLE);
  assign out_valid         = (state_r == alist_pkg::S_OUT);
  assign out_status        = status_r;
  assign out_found         = found_r;
  assign out_removed_value = removed_r;
  assign out_entry_count   = cnt_out_ext[OUT_W-1:0];
  assign out_is_empty      = (count_r == '0);

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("list count above capacity");

  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == alist_pkg::S_IDLE || state_r == alist_pkg::S_RM))
    else $error("RAM write outside insert or remove");

  a_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready)
    else $error("not ready after result beat");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == alist_pkg::STAT_OK && out_removed_value == '0))
    else $error("found set on a result that is not a search");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(count_r))
    else $error("count moved while result waits");

endmodule

`default_nettype wire

@@ tb/list_checker.sv @@
`default_nettype none

module list_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_ready,
  input  wire logic [1:0]                           in_func,
  input  wire logic signed [alist_pkg::DATA_W-1:0]  in_item_value,
  input  wire logic [alist_pkg::POS_W-1:0]          in_position,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_ready,
  input  wire logic [1:0]                           out_status,
  input  wire logic                                 out_found,
  input  wire logic signed [alist_pkg::DATA_W-1:0]  out_removed_value,
  input  wire logic [alist_pkg::COUNT_OUT_W-1:0]    out_entry_count,
  input  wire logic                                 out_is_empty,
  output int                                        err_count,
  output int                                        pend_count
);

  import alist_pkg::*;

  localparam int REPORT_MAX = 10;

  typedef struct {
    status_t                  status;
    logic                     found;
    logic signed [DATA_W-1:0] removed;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     empty;
  } list_result_t;

  // shadow copy of the list contents
  logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
  int                       list_len;
  list_result_t             result_q [$];

  // carry out one operation on the shadow list and work out its result beat
  task automatic apply_list_op(input op_t op, input logic signed [DATA_W-1:0] val,
                               input logic [POS_W-1:0] pos, output list_result_t res);
    int i;
    res.status  = STAT_OK;
    res.found   = 1'b0;
    res.removed = '0;
    case (op)
      OP_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < list_len; i++)
          if (list_mem[i] == val) res.found = 1'b1;
      end
      OP_REMOVE: begin
        if (int'(pos) >= list_len) begin
          res.status = STAT_MISSING;
        end else begin
          res.removed = list_mem[pos];
          list_len--;
          for (i = int'(pos); i < list_len; i++) list_mem[i] = list_mem[i + 1];
        end
      end
      default: list_len = 0;
    endcase
    res.count = list_len[COUNT_OUT_W-1:0];
    res.empty = (list_len == 0);
  endtask

  task automatic check_field(input string fname, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= REPORT_MAX)
        $display("[%0t] mismatch on %s: expected %h, got %h", $time, fname, want, got);
    end
  endtask

  // result beats are matched before new input beats: the block holds one item at a time
  always @(posedge clk) begin
    list_result_t want_r;
    if (!rst_n) begin
      list_len = 0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("[%0t] result beat with nothing pending: status %0d count %0d",
                     $time, out_status, out_entry_count);
        end else begin
          want_r = result_q.pop_front();
          check_field("status", want_r.status, out_status);
          check_field("found", want_r.found, out_found);
          check_field("removed_value", want_r.removed, out_removed_value);
          check_field("entry_count", want_r.count, out_entry_count);
          check_field("is_empty", want_r.empty, out_is_empty);
        end
      end
      if (in_valid && in_ready) begin
        apply_list_op(op_t'(in_func), in_item_value, in_position, want_r);
        result_q.push_back(want_r);
      end
    end
    pend_count <= result_q.size();
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;

  import alist_pkg::*;

  localparam int PHASE_ITEMS = 450;
  localparam int SEG_LEN     = 75;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 80;
  localparam int POOL_SIZE   = 16;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_func       = OP_INSERT;
  logic signed [DATA_W-1:0]   in_item_value = '0;
  logic [POS_W-1:0]           in_position   = '0;
  logic                       out_valid;
  logic                       out_ready     = 1'b0;
  logic [1:0]                 out_status;
  logic                       out_found;
  logic signed [DATA_W-1:0]   out_removed_value;
  logic [COUNT_OUT_W-1:0]     out_entry_count;
  logic                       out_is_empty;

  int  err_count;
  int  pend_count;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_req    = 1'b0;
  int  stall_cyc   = 0;

  // values reused for inserts and search keys so that searches hit
  logic signed [DATA_W-1:0] key_pool [POOL_SIZE];

  always #1 clk = ~clk;

  array_list_engine_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_item_value     (in_item_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count),
    .out_is_empty      (out_is_empty)
  );

  list_checker u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_item_value     (in_item_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count),
    .out_is_empty      (out_is_empty),
    .err_count         (err_count),
    .pend_count        (pend_count)
  );

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // watchdog: too long without any beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cyc <= 0;
    end else if (stall_cyc >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cyc <= stall_cyc + 1;
    end
  end

  task automatic send_item(input op_t op, input logic signed [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= op;
    in_item_value <= val;
    in_position   <= pos;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait until every result beat is back
  task automatic wait_all_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pend_count != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return '0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // favor low positions and the tail of a full list
  function automatic logic [POS_W-1:0] pick_pos;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return POS_W'($urandom_range(0, 63));
    if (r < 70) return POS_W'($urandom_range(0, 7));
    return POS_W'($urandom_range(48, 63));
  endfunction

  function automatic op_t pick_op(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return (r < 88) ? OP_INSERT : (r < 97) ? OP_SEARCH : OP_REMOVE;
      MIX_DRAIN: return (r < 70) ? OP_REMOVE : (r < 90) ? OP_SEARCH :
                        (r < 98) ? OP_INSERT : OP_CLEAR;
      default:   return (r < 35) ? OP_INSERT : (r < 65) ? OP_SEARCH :
                        (r < 95) ? OP_REMOVE : OP_CLEAR;
    endcase
  endfunction

  function automatic mix_t seg_mix(input int seg);
    case (seg % 6)
      0, 4:    return MIX_FILL;
      2, 5:    return MIX_DRAIN;
      default: return MIX_BALANCED;
    endcase
  endfunction

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) begin
      send_item(pick_op(seg_mix(k / SEG_LEN)), pick_value(), pick_pos());
      if ($urandom_range(0, 49) == 0) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 38;
    rx_idle_pct = 46;

    // empty list corner cases
    send_item(OP_SEARCH, '0, '0);
    send_item(OP_REMOVE, '0, '0);
    send_item(OP_CLEAR, -32'sd1, 6'h3f);
    // extremes in, then hits at both ends and a miss over a full scan
    send_item(OP_INSERT, 32'sh8000_0000, 6'h3f);
    send_item(OP_INSERT, 32'sh7fff_ffff, 6'h15);
    send_item(OP_INSERT, '0, 6'h2a);
    send_item(OP_INSERT, -32'sd1, '0);
    send_item(OP_SEARCH, -32'sd1, 6'h3f);
    send_item(OP_SEARCH, 32'sh8000_0000, '0);
    send_item(OP_SEARCH, 32'sd12345, '0);
    // removes: out of range, at count, last entry, first entry with shift
    send_item(OP_REMOVE, '0, 6'd63);
    send_item(OP_REMOVE, '0, 6'd4);
    send_item(OP_REMOVE, '0, 6'd3);
    send_item(OP_REMOVE, -32'sd1, 6'd0);
    send_item(OP_SEARCH, 32'sh8000_0000, '0);
    send_item(OP_INSERT, 32'sh5555_5555, 6'h2a);
    send_item(OP_INSERT, 32'shaaaa_aaaa, 6'h15);
    send_item(OP_REMOVE, '0, 6'd1);
    // stale entries must not be seen after a clear
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_SEARCH, 32'sh7fff_ffff, '0);
    send_item(OP_REMOVE, '0, 6'd0);

    run_random(PHASE_ITEMS);
    wait_all_results();

    tx_idle_pct = 46;
    rx_idle_pct = 38;
    run_random(PHASE_ITEMS);
    wait_all_results();

    // no idling; the receiver starts with a long hold-off
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    run_random(PHASE_ITEMS);

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pend_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
